// ===== src/esk_pkg.sv =====
`timescale 1ns / 1ps

package esk_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int KEY_W       = 16;
  localparam int TAG_W       = 8;

  typedef struct packed {
    logic [KEY_W-1:0] sort_key;
    logic [TAG_W-1:0] record_tag;
    logic             last_item;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic             end_of_batch;
    logic             overflow;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    rec_t             wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== src/esk_store.sv =====
`timescale 1ns / 1ps

module esk_store (
  input  logic            clk,
  input  esk_pkg::mem_req_t req,
  output esk_pkg::rec_t   rdata
);
  import esk_pkg::*;

  rec_t mem [MAX_RECORDS];
  rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/esk_ctrl.sv =====
`timescale 1ns / 1ps

module esk_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  esk_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output esk_pkg::out_item_t out_data,
  output esk_pkg::mem_req_t  mreq,
  input  esk_pkg::rec_t      rdata
);
  import esk_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDI  = 3'd1;
  localparam logic [2:0] S_LDI  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_ERD  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             drop_r, drop_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  rec_t             cur_r, cur_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic             is_end;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign is_end    = (CNT_W'(k_r) == count_r - CNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    mreq          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (count_r < CNT_W'(MAX_RECORDS)) begin
            mreq.we    = 1'b1;
            mreq.waddr = count_r[IDX_W-1:0];
            mreq.wdata = '{key: in_data.sort_key, tag: in_data.record_tag};
            count_nxt  = count_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            i_nxt     = '0;
            k_nxt     = '0;
            state_nxt = (count_nxt == CNT_W'(1)) ? S_ERD : S_RDI;
          end
        end
      end
      S_RDI: begin
        mreq.raddr = i_r;
        state_nxt  = S_LDI;
      end
      S_LDI: begin
        cur_nxt    = rdata;
        j_nxt      = i_r + IDX_W'(1);
        mreq.raddr = i_r + IDX_W'(1);
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        if (cur_r.key > rdata.key) begin
          mreq.we    = 1'b1;
          mreq.waddr = j_r;
          mreq.wdata = cur_r;
          cur_nxt    = rdata;
        end
        if (CNT_W'(j_r) == count_r - CNT_W'(1)) begin
          state_nxt = S_WB;
        end else begin
          j_nxt      = j_r + IDX_W'(1);
          mreq.raddr = j_r + IDX_W'(1);
        end
      end
      S_WB: begin
        mreq.we    = 1'b1;
        mreq.waddr = i_r;
        mreq.wdata = cur_r;
        i_nxt      = i_r + IDX_W'(1);
        if (CNT_W'(i_r) + CNT_W'(2) < count_r) begin
          mreq.raddr = i_r + IDX_W'(1);
          state_nxt  = S_LDI;
        end else begin
          k_nxt     = '0;
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        mreq.raddr = k_r;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        mreq.raddr = k_r;
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.sorted_key   = rdata.key;
          out_nxt.sorted_tag   = rdata.tag;
          out_nxt.end_of_batch = is_end;
          out_nxt.overflow     = drop_r;
          if (is_end) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt      = k_r + IDX_W'(1);
            mreq.raddr = k_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

endmodule

// ===== src/exchange_sort_keys_with_tags_top.sv =====
`timescale 1ns / 1ps
// channel  direction  handshake             payload
// in_      input      in_valid / in_stall   in_data   (esk_pkg::in_item_t)
// out_     output     out_valid / out_stall out_data  (esk_pkg::out_item_t)
//
// Load: one item per cycle until the item marked last; in_stall is high from then
// until the final sorted record is registered for output.
// Sort: one shared key comparator over a 1R1W store; each outer position i loads
// mem[i], makes n-1-i compares, then writes the smallest key back to position i.
// Emit: after a read state, one record per cycle while not stalled; out_stall holds the output register.
// Synchronous active-low reset empties the batch; the store itself is not cleared.

module exchange_sort_keys_with_tags_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  esk_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output esk_pkg::out_item_t out_data
);
  import esk_pkg::*;

  mem_req_t mreq;
  rec_t     rdata;

  esk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mreq      (mreq),
    .rdata     (rdata)
  );

  esk_store u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

endmodule

// ===== tb/exchange_sort_keys_with_tags_top_tb.sv =====
`timescale 1ns / 1ps

module exchange_sort_keys_with_tags_top_tb;
  import esk_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 350;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  logic [KEY_W-1:0] batch_keys [MAX_RECORDS];
  logic [TAG_W-1:0] batch_tags [MAX_RECORDS];
  int               batch_count;
  bit               batch_dropped;
  out_item_t        sorted_records [$];

  int fail_count;
  int quiet_cycles;
  int recv_hold;
  bit send_idle;
  bit recv_idle;
  int items_sent;

  exchange_sort_keys_with_tags_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirrors the block: store in arrival order, exchange sort on the last item
  task automatic absorb_record(input in_item_t it);
    int               i;
    int               j;
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    out_item_t        r;
    if (batch_count < MAX_RECORDS) begin
      batch_keys[batch_count] = it.sort_key;
      batch_tags[batch_count] = it.record_tag;
      batch_count++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (it.last_item) begin
      for (i = 0; i + 1 < batch_count; i++) begin
        for (j = i + 1; j < batch_count; j++) begin
          if (batch_keys[i] > batch_keys[j]) begin
            k = batch_keys[i];
            t = batch_tags[i];
            batch_keys[i] = batch_keys[j];
            batch_tags[i] = batch_tags[j];
            batch_keys[j] = k;
            batch_tags[j] = t;
          end
        end
      end
      for (i = 0; i < batch_count; i++) begin
        r.sorted_key   = batch_keys[i];
        r.sorted_tag   = batch_tags[i];
        r.end_of_batch = (i + 1 == batch_count);
        r.overflow     = batch_dropped;
        sorted_records.push_back(r);
      end
      batch_count   = 0;
      batch_dropped = 1'b0;
    end
  endtask

  task automatic send_item(input in_item_t it);
    int gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    absorb_record(it);
    items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    release_input();
    while (sorted_records.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int style);
    case (style)
      0: pick_key = KEY_W'($urandom);
      1: pick_key = KEY_W'($urandom_range(0, 7));
      default: begin
        case ($urandom_range(0, 3))
          0: pick_key = '0;
          1: pick_key = '1;
          2: pick_key = {1'b0, {(KEY_W-1){1'b1}}};
          default: pick_key = {1'b1, {(KEY_W-1){1'b0}}};
        endcase
      end
    endcase
  endfunction

  task automatic send_batch(input int n, input int style);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.sort_key   = pick_key(style);
      it.record_tag = TAG_W'($urandom);
      it.last_item  = (i == n - 1);
      send_item(it);
    end
  endtask

  task automatic test_single_records();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_item('{sort_key: '0, record_tag: '0, last_item: 1'b1});
    send_item('{sort_key: '1, record_tag: '1, last_item: 1'b1});
  endtask

  task automatic test_key_extremes();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_item('{sort_key: 16'hffff, record_tag: 8'h01, last_item: 1'b0});
    send_item('{sort_key: 16'h0000, record_tag: 8'hff, last_item: 1'b0});
    send_item('{sort_key: 16'hffff, record_tag: 8'h02, last_item: 1'b0});
    send_item('{sort_key: 16'h8000, record_tag: 8'h80, last_item: 1'b0});
    send_item('{sort_key: 16'h7fff, record_tag: 8'h7f, last_item: 1'b1});
  endtask

  // descending keys fill the store; the last item arrives when full and is dropped
  task automatic test_store_overflow();
    in_item_t it;
    send_idle = 1'b0;
    recv_idle = 1'b1;
    for (int i = 0; i <= MAX_RECORDS; i++) begin
      it.sort_key   = KEY_W'(16'hf000 - i * 16'h0f00);
      it.record_tag = TAG_W'(i);
      it.last_item  = (i == MAX_RECORDS);
      send_item(it);
    end
  endtask

  task automatic test_overflow_clears();
    send_idle = 1'b1;
    recv_idle = 1'b0;
    send_batch(2, 1);
  endtask

  task automatic test_batch_after_drain();
    send_idle = 1'b0;
    recv_idle = 1'b1;
    send_batch(5, 0);
    wait_for_drain();
    send_batch(MAX_RECORDS, 1);
  endtask

  task automatic test_random_batches();
    int n;
    int pick;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)      n = $urandom_range(1, 8);
      else if (pick < 8) n = $urandom_range(9, MAX_RECORDS);
      else if (pick == 8) n = MAX_RECORDS;
      else               n = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 8);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) wait_for_drain();
      send_batch(n, $urandom_range(0, 2));
    end
  endtask

  always @(negedge clk) begin
    if (recv_hold > 0) begin
      out_stall <= 1'b1;
      recv_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t exp_rec;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_records.size() == 0) begin
        $error("unexpected item: key %h tag %h", out_data.sorted_key, out_data.sorted_tag);
        fail_count++;
      end else begin
        exp_rec = sorted_records.pop_front();
        if (out_data.sorted_key !== exp_rec.sorted_key) begin
          $error("sorted_key: expected %h, got %h", exp_rec.sorted_key, out_data.sorted_key);
          fail_count++;
        end
        if (out_data.sorted_tag !== exp_rec.sorted_tag) begin
          $error("sorted_tag: expected %h, got %h", exp_rec.sorted_tag, out_data.sorted_tag);
          fail_count++;
        end
        if (out_data.end_of_batch !== exp_rec.end_of_batch) begin
          $error("end_of_batch: expected %b, got %b", exp_rec.end_of_batch,
                 out_data.end_of_batch);
          fail_count++;
        end
        if (out_data.overflow !== exp_rec.overflow) begin
          $error("overflow: expected %b, got %b", exp_rec.overflow, out_data.overflow);
          fail_count++;
        end
      end
      recv_hold = recv_idle ? $urandom_range(0, 7) : 0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[exchange_sort_keys_with_tags_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    recv_hold     = 0;
    quiet_cycles  = 0;
    fail_count    = 0;
    batch_count   = 0;
    batch_dropped = 1'b0;
    send_idle     = 1'b0;
    recv_idle     = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_single_records();
    test_key_extremes();
    test_store_overflow();
    test_overflow_clears();
    test_batch_after_drain();
    test_random_batches();

    wait_for_drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("[exchange_sort_keys_with_tags_top] OK");
    end else begin
      $display("[exchange_sort_keys_with_tags_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/esk_pkg.sv
src/esk_store.sv
src/esk_ctrl.sv
src/exchange_sort_keys_with_tags_top.sv
tb/exchange_sort_keys_with_tags_top_tb.sv
